/* hw/rtl/mrpt_pkg.sv */
package mrpt_pkg;

  localparam int unsigned NumWidthDefault = 32;
  localparam int unsigned FieldWidth = 32;

  typedef enum logic [1:0] {
    VERDICT_COMPOSITE = 2'd0,
    VERDICT_PRIME     = 2'd1,
    VERDICT_PROBABLE  = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    CLS_COMPOSITE = 2'd0,
    CLS_PRIME     = 2'd1,
    CLS_TEST      = 2'd2
  } cls_e;

  typedef enum logic [1:0] {
    MSRC_REDUCE = 2'd0,
    MSRC_SQUARE = 2'd1,
    MSRC_MULT   = 2'd2
  } msrc_e;

  typedef struct packed {
    logic  load;
    logic  mul_start;
    msrc_e mul_src;
    logic  split_shift;
    logic  exp_shift;
    logic  s_dec;
    logic  emit;
    logic  round_fail;
  } dp_cmd_t;

  typedef struct packed {
    cls_e cls;
    logic d_lsb;
    logic d_msb;
    logic last_bit;
    logic s_zero;
    logic x_is_one;
    logic x_is_nm1;
    logic mul_done;
    logic out_free;
  } dp_status_t;

endpackage

/* hw/rtl/mrpt_modmul.sv */
module mrpt_modmul #(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_WIDTH-1:0] x_i,
  input  logic [NUM_WIDTH-1:0] y_i,
  input  logic [NUM_WIDTH-1:0] n_i,
  output logic                 done_o,
  output logic [NUM_WIDTH-1:0] res_o
);

  // The operand y and the running sum stay below n; the modulus must be at least 2.
  localparam int unsigned EW = NUM_WIDTH + 3;
  localparam int unsigned CW = $clog2(NUM_WIDTH + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [NUM_WIDTH-1:0] x_q, x_d;
  logic [NUM_WIDTH-1:0] y_q, y_d;
  logic [NUM_WIDTH-1:0] acc_q, acc_d;
  logic [NUM_WIDTH-1:0] y_sel;
  logic [EW-1:0]        p0, p1, p2;
  logic [NUM_WIDTH-1:0] step;

  always_comb begin
    y_sel = x_q[NUM_WIDTH-1] ? y_q : '0;
    p0 = {2'b00, acc_q, 1'b0} + {3'b000, y_sel};
    p1 = {2'b00, acc_q, 1'b0} + {3'b000, y_sel} - {3'b000, n_i};
    p2 = {2'b00, acc_q, 1'b0} + {3'b000, y_sel} - {2'b00, n_i, 1'b0};
    priority if (!p2[EW-1]) begin
      step = p2[NUM_WIDTH-1:0];
    end else if (!p1[EW-1]) begin
      step = p1[NUM_WIDTH-1:0];
    end else begin
      step = p0[NUM_WIDTH-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NUM_WIDTH);
      x_d    = x_i;
      y_d    = y_i;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = step;
      x_d   = {x_q[NUM_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

/* hw/rtl/mrpt_dp.sv */
module mrpt_dp #(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mrpt_pkg::dp_cmd_t                 cmd_i,
  output mrpt_pkg::dp_status_t              status_o,
  input  logic [mrpt_pkg::FieldWidth-1:0]   candidate_i,
  input  logic [mrpt_pkg::FieldWidth-1:0]   base_i,
  input  logic                              last_base_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        verdict_o,
  output logic                              final_res_o
);

  import mrpt_pkg::*;

  localparam int unsigned SW = $clog2(NUM_WIDTH);
  localparam int unsigned CW = $clog2(NUM_WIDTH + 1);
  localparam logic [NUM_WIDTH-1:0] One = {{(NUM_WIDTH-1){1'b0}}, 1'b1};
  localparam logic [NUM_WIDTH-1:0] Two = {{(NUM_WIDTH-2){1'b0}}, 2'b10};
  localparam logic [NUM_WIDTH-1:0] Three = {{(NUM_WIDTH-2){1'b0}}, 2'b11};

  logic [NUM_WIDTH-1:0] n_q, a_q, b_q, acc_q, d_q;
  logic [SW-1:0]        s_q;
  logic [CW-1:0]        bit_cnt_q;
  logic                 last_q;
  msrc_e                msrc_q;
  logic                 comp_q, comp_d;
  logic                 out_valid_q, out_valid_d;
  verdict_e             verdict_q, verdict_d;
  logic                 final_q, final_d;

  logic [NUM_WIDTH-1:0] cand_w, nm1;
  logic [NUM_WIDTH-1:0] mul_x, mul_y, mul_res;
  logic                 mul_done;
  cls_e                 cls;
  logic                 seen;

  assign cand_w = candidate_i[NUM_WIDTH-1:0];
  assign nm1    = n_q - One;

  always_comb begin
    if (!n_q[0]) begin
      cls = (n_q == Two) ? CLS_PRIME : CLS_COMPOSITE;
    end else if (n_q == Three) begin
      cls = CLS_PRIME;
    end else if (n_q == One) begin
      cls = CLS_COMPOSITE;
    end else begin
      cls = CLS_TEST;
    end
  end

  always_comb begin
    unique case (cmd_i.mul_src)
      MSRC_REDUCE: begin
        mul_x = a_q;
        mul_y = One;
      end
      MSRC_SQUARE: begin
        mul_x = acc_q;
        mul_y = acc_q;
      end
      MSRC_MULT: begin
        mul_x = acc_q;
        mul_y = b_q;
      end
      default: begin
        mul_x = acc_q;
        mul_y = acc_q;
      end
    endcase
  end

  mrpt_modmul #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .x_i    (mul_x),
    .y_i    (mul_y),
    .n_i    (n_q),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q       <= cand_w;
      a_q       <= base_i[NUM_WIDTH-1:0];
      last_q    <= last_base_i;
      d_q       <= cand_w - One;
      s_q       <= '0;
      acc_q     <= One;
      bit_cnt_q <= CW'(NUM_WIDTH);
    end else begin
      if (cmd_i.split_shift) begin
        d_q <= {1'b0, d_q[NUM_WIDTH-1:1]};
        s_q <= s_q + SW'(1);
      end
      if (cmd_i.exp_shift) begin
        d_q       <= {d_q[NUM_WIDTH-2:0], 1'b0};
        bit_cnt_q <= bit_cnt_q - CW'(1);
      end
      if (cmd_i.s_dec) begin
        s_q <= s_q - SW'(1);
      end
      if (mul_done) begin
        if (msrc_q == MSRC_REDUCE) begin
          b_q <= mul_res;
        end else begin
          acc_q <= mul_res;
        end
      end
    end
    if (cmd_i.mul_start) begin
      msrc_q <= cmd_i.mul_src;
    end
  end

  always_comb begin
    seen        = comp_q | cmd_i.round_fail;
    comp_d      = comp_q;
    verdict_d   = verdict_q;
    final_d     = final_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      unique case (cls)
        CLS_PRIME: begin
          verdict_d = VERDICT_PRIME;
          final_d   = 1'b1;
          comp_d    = 1'b0;
        end
        CLS_COMPOSITE: begin
          verdict_d = VERDICT_COMPOSITE;
          final_d   = 1'b1;
          comp_d    = 1'b0;
        end
        CLS_TEST: begin
          verdict_d = seen ? VERDICT_COMPOSITE : VERDICT_PROBABLE;
          final_d   = last_q;
          comp_d    = last_q ? 1'b0 : seen;
        end
        default: begin
          verdict_d = VERDICT_COMPOSITE;
          final_d   = 1'b1;
          comp_d    = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      comp_q      <= comp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
    final_q   <= final_d;
  end

  always_comb begin
    status_o.cls      = cls;
    status_o.d_lsb    = d_q[0];
    status_o.d_msb    = d_q[NUM_WIDTH-1];
    status_o.last_bit = (bit_cnt_q == CW'(1));
    status_o.s_zero   = (s_q == '0);
    status_o.x_is_one = (acc_q == One);
    status_o.x_is_nm1 = (acc_q == nm1);
    status_o.mul_done = mul_done;
    status_o.out_free = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign final_res_o = final_q;

endmodule

/* hw/rtl/mrpt_ctrl.sv */
module mrpt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output mrpt_pkg::dp_cmd_t    cmd_o,
  input  mrpt_pkg::dp_status_t status_i
);

  import mrpt_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE        = 12'b0000_0000_0001,
    ST_CLASSIFY    = 12'b0000_0000_0010,
    ST_REDUCE      = 12'b0000_0000_0100,
    ST_SPLIT       = 12'b0000_0000_1000,
    ST_EXP_SQ      = 12'b0000_0001_0000,
    ST_EXP_SQ_DONE = 12'b0000_0010_0000,
    ST_EXP_MUL     = 12'b0000_0100_0000,
    ST_EXP_NEXT    = 12'b0000_1000_0000,
    ST_CHECK       = 12'b0001_0000_0000,
    ST_SQ_WAIT     = 12'b0010_0000_0000,
    ST_SQ_CHECK    = 12'b0100_0000_0000,
    ST_RESULT      = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   fail_q, fail_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    fail_d  = fail_q;
    cmd_o   = '0;
    cmd_o.mul_src    = MSRC_SQUARE;
    cmd_o.round_fail = fail_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        fail_d = 1'b0;
        if (status_i.cls == CLS_TEST) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_src   = MSRC_REDUCE;
          state_d         = ST_REDUCE;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_REDUCE: begin
        if (status_i.mul_done) begin
          state_d = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (!status_i.d_lsb) begin
          cmd_o.split_shift = 1'b1;
        end else begin
          cmd_o.mul_start = 1'b1;
          state_d         = ST_EXP_SQ;
        end
      end
      ST_EXP_SQ: begin
        if (status_i.mul_done) begin
          state_d = ST_EXP_SQ_DONE;
        end
      end
      ST_EXP_SQ_DONE: begin
        if (status_i.d_msb) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_src   = MSRC_MULT;
          state_d         = ST_EXP_MUL;
        end else begin
          state_d = ST_EXP_NEXT;
        end
      end
      ST_EXP_MUL: begin
        if (status_i.mul_done) begin
          state_d = ST_EXP_NEXT;
        end
      end
      ST_EXP_NEXT: begin
        cmd_o.exp_shift = 1'b1;
        if (status_i.last_bit) begin
          state_d = ST_CHECK;
        end else begin
          cmd_o.mul_start = 1'b1;
          state_d         = ST_EXP_SQ;
        end
      end
      ST_CHECK: begin
        priority if (status_i.x_is_one || status_i.x_is_nm1) begin
          fail_d  = 1'b0;
          state_d = ST_RESULT;
        end else if (status_i.s_zero) begin
          fail_d  = 1'b1;
          state_d = ST_RESULT;
        end else begin
          cmd_o.mul_start = 1'b1;
          state_d         = ST_SQ_WAIT;
        end
      end
      ST_SQ_WAIT: begin
        if (status_i.mul_done) begin
          cmd_o.s_dec = 1'b1;
          state_d     = ST_SQ_CHECK;
        end
      end
      ST_SQ_CHECK: begin
        priority if (status_i.x_is_one) begin
          fail_d  = 1'b1;
          state_d = ST_RESULT;
        end else if (status_i.x_is_nm1) begin
          fail_d  = 1'b0;
          state_d = ST_RESULT;
        end else if (status_i.s_zero) begin
          fail_d  = 1'b1;
          state_d = ST_RESULT;
        end else begin
          cmd_o.mul_start = 1'b1;
          state_d         = ST_SQ_WAIT;
        end
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fail_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fail_q  <= fail_d;
    end
  end

endmodule

/* hw/rtl/miller_rabin_prime_tester_core.sv */
// Miller-Rabin tester that runs one round per input beat and returns one result beat per
// input beat. Even candidates and candidates of 3 or less are classified directly, with no
// modular multiplication. Any other candidate goes through the base reduction, the split
// of n - 1 into its s factors of two and its odd part d, the square-and-multiply
// exponentiation over the bits of d and the squaring steps, so its run time depends on the
// number of set bits in d and on the number of squarings. A result that is still stalled
// at the output holds back the next result until it is taken.
// The modular multiplier is bit-serial: it retires one multiplier bit per cycle and is
// shared by the base reduction, the exponentiation and the squaring steps.
// One round is in flight at a time, and a finished result waits in the output register
// while the next beat is accepted. The composite flag covers all beats up to the next
// beat that carries a final result.
module miller_rabin_prime_tester_core #(
  parameter int unsigned NUM_WIDTH = mrpt_pkg::NumWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [mrpt_pkg::FieldWidth-1:0] candidate_i,
  input  logic [mrpt_pkg::FieldWidth-1:0] base_i,
  input  logic                            last_base_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      verdict_o,
  output logic                            final_res_o
);

  import mrpt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mrpt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd),
    .status_i  (status)
  );

  mrpt_dp #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .candidate_i(candidate_i),
    .base_i     (base_i),
    .last_base_i(last_base_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .verdict_o  (verdict_o),
    .final_res_o(final_res_o)
  );

endmodule

/* bench/mrpt_round_checker.sv */
`timescale 1ns / 100ps

module mrpt_round_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [mrpt_pkg::FieldWidth-1:0] candidate_i,
  input  logic [mrpt_pkg::FieldWidth-1:0] base_i,
  input  logic                            last_base_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [1:0]                      verdict_i,
  input  logic                            final_res_i,
  output int                              errors_o,
  output int                              pending_o,
  output int                              checked_o,
  output int                              closed_o
);
  import mrpt_pkg::*;

  typedef struct packed {
    verdict_e verdict;
    logic     final_res;
  } round_result_t;

  round_result_t expected_q[$];
  logic          composite_seen;
  int            errors  = 0;
  int            checked = 0;
  int            closed  = 0;

  function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] n);
    return (x * y) % n;
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e, logic [63:0] n);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1 % n;
    sq  = b % n;
    while (e != 0) begin
      if (e[0]) begin
        acc = mul_mod(acc, sq, n);
      end
      sq = mul_mod(sq, sq, n);
      e  = e >> 1;
    end
    return acc;
  endfunction

  // True when base a proves the odd n (n of 5 or more) composite.
  function automatic logic witness_found(logic [63:0] n, logic [63:0] a);
    logic [63:0] nm1;
    logic [63:0] d;
    logic [63:0] x;
    int          s;
    nm1 = n - 1;
    d   = nm1;
    s   = 0;
    while (d[0] == 1'b0) begin
      d = d >> 1;
      s++;
    end
    x = pow_mod(a, d, n);
    if (x == 1 || x == nm1) begin
      return 1'b0;
    end
    for (int r = 1; r <= s; r++) begin
      x = mul_mod(x, x, n);
      if (x == 1) begin
        return 1'b1;
      end
      if (x == nm1) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void predict_round(logic [31:0] cand, logic [31:0] base, logic last);
    round_result_t res;
    if (!cand[0]) begin
      res.verdict    = (cand == 32'd2) ? VERDICT_PRIME : VERDICT_COMPOSITE;
      res.final_res  = 1'b1;
      composite_seen = 1'b0;
    end else if (cand == 32'd3) begin
      res.verdict    = VERDICT_PRIME;
      res.final_res  = 1'b1;
      composite_seen = 1'b0;
    end else if (cand == 32'd1) begin
      res.verdict    = VERDICT_COMPOSITE;
      res.final_res  = 1'b1;
      composite_seen = 1'b0;
    end else begin
      if (witness_found({32'd0, cand}, {32'd0, base})) begin
        composite_seen = 1'b1;
      end
      res.verdict   = composite_seen ? VERDICT_COMPOSITE : VERDICT_PROBABLE;
      res.final_res = last;
      if (last) begin
        composite_seen = 1'b0;
      end
    end
    expected_q.push_back(res);
  endfunction

  task automatic report_mismatch(string what, int got, int want_v);
    $display("MISMATCH at %0t ns, result beat %0d: %s: got %0d, want %0d",
             $time, checked, what, got, want_v);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    round_result_t want;
    if (!rst_ni) begin
      composite_seen = 1'b0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with nothing expected", verdict_i, -1);
        end else begin
          want = expected_q.pop_front();
          if (verdict_i !== want.verdict) begin
            report_mismatch("verdict", verdict_i, want.verdict);
          end
          if (final_res_i !== want.final_res) begin
            report_mismatch("final_res", final_res_i, want.final_res);
          end
          if (want.final_res) begin
            closed++;
          end
        end
        checked++;
      end
      if (in_valid_i && !in_stall_i) begin
        predict_round(candidate_i, base_i, last_base_i);
      end
      pending_o <= expected_q.size();
      errors_o  <= errors;
      checked_o <= checked;
      closed_o  <= closed;
    end
  end

endmodule

/* bench/miller_rabin_prime_tester_core_test.sv */
`timescale 1ns / 100ps

module miller_rabin_prime_tester_core_test;
  import mrpt_pkg::*;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [FieldWidth-1:0] candidate_i = '0;
  logic [FieldWidth-1:0] base_i      = '0;
  logic                  last_base_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [1:0]            verdict_o;
  logic                  final_res_o;

  int   mismatches;
  int   pending;
  int   checked;
  int   closed;
  int   rounds_sent = 0;
  int   stall_left  = 0;
  logic quiet       = 1'b0;

  miller_rabin_prime_tester_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .candidate_i (candidate_i),
    .base_i      (base_i),
    .last_base_i (last_base_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .verdict_o   (verdict_o),
    .final_res_o (final_res_o)
  );

  mrpt_round_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .candidate_i (candidate_i),
    .base_i      (base_i),
    .last_base_i (last_base_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .verdict_i   (verdict_o),
    .final_res_i (final_res_o),
    .errors_o    (mismatches),
    .pending_o   (pending),
    .checked_o   (checked),
    .closed_o    (closed)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // The receiver mostly takes results at once, with rare bursts of back pressure,
  // some of them longer than a whole round.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 1999) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= ($urandom_range(0, 3) == 0) ? $urandom_range(100, 2600)
                                                  : $urandom_range(1, 12);
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 15) == 0);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 8);
    end
    return $urandom_range(100, 2600);
  endfunction

  function automatic logic [31:0] pick_candidate();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      case ($urandom_range(0, 12))
        0:       return 32'd5;
        1:       return 32'd7;
        2:       return 32'd13;
        3:       return 32'd97;
        4:       return 32'd7919;
        5:       return 32'd65537;
        6:       return 32'd104729;
        7:       return 32'd999983;
        8:       return 32'd1000000007;
        9:       return 32'd998244353;
        10:      return 32'd2147483647;
        11:      return 32'd4294967279;
        default: return 32'd4294967291;
      endcase
    end else if (r < 55) begin
      case ($urandom_range(0, 6))
        0:       return 32'd2047;
        1:       return 32'd1373653;
        2:       return 32'd25326001;
        3:       return 32'd3215031751;
        4:       return 32'd561;
        5:       return 32'd1105;
        default: return 32'd3277;
      endcase
    end else if (r < 75) begin
      return $urandom() | 32'd1;
    end else if (r < 85) begin
      return 32'($urandom_range(2, 127)) * 32'd2 + 32'd1;
    end else if (r < 93) begin
      return $urandom() & ~32'd1;
    end
    return 32'($urandom_range(0, 3));
  endfunction

  function automatic logic [31:0] pick_base(logic [31:0] n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(2, n - 2);
    end else if (r < 78) begin
      return 32'($urandom_range(2, 7));
    end else if (r < 84) begin
      return 32'($urandom_range(0, 1));
    end else if (r < 90) begin
      return ($urandom_range(0, 1) == 0) ? n - 32'd1 : n;
    end
    return $urandom();
  endfunction

  task automatic send_round(logic [31:0] cand, logic [31:0] base, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    candidate_i <= cand;
    base_i      <= base;
    last_base_i <= last;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    rounds_sent++;
  endtask

  // A well-formed test is a run of rounds on one candidate closed by a final round.
  // Now and then a stray round of another candidate is slipped in, or the final
  // mark is left off so that the composite flag carries into the next test.
  task automatic run_sequence();
    logic [31:0] cand;
    int          rounds;
    logic        last;
    cand = pick_candidate();
    if (!cand[0] || cand < 32'd5) begin
      send_round(cand, $urandom(), 1'($urandom_range(0, 1)));
    end else begin
      rounds = $urandom_range(1, 5);
      for (int r = 0; r < rounds; r++) begin
        last = (r == rounds - 1) && ($urandom_range(0, 19) != 0);
        if (!last && $urandom_range(0, 9) == 0) begin
          send_round(pick_candidate(), $urandom(), 1'($urandom_range(0, 1)));
        end
        send_round(cand, pick_base(cand), last);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_round(32'd0, 32'hFFFF_FFFF, 1'b0);
    send_round(32'd2, 32'd0, 1'b1);
    send_round(32'd4, 32'd5, 1'b0);
    send_round(32'hFFFF_FFFE, 32'd3, 1'b1);
    send_round(32'd1, 32'd7, 1'b0);
    send_round(32'd3, 32'd0, 1'b0);
    send_round(32'd5, 32'd2, 1'b1);
    send_round(32'd4294967291, 32'd0, 1'b0);
    send_round(32'd4294967291, 32'd2, 1'b1);
    send_round(32'd4294967291, 32'd1, 1'b0);
    send_round(32'd4294967291, 32'd4294967290, 1'b0);
    send_round(32'd4294967291, 32'hFFFF_FFFF, 1'b1);
    send_round(32'hFFFF_FFFF, 32'd2, 1'b1);
    send_round(32'd2047, 32'd2, 1'b0);
    send_round(32'd2047, 32'd3, 1'b1);
    send_round(32'd561, 32'd2, 1'b1);
    send_round(32'd3215031751, 32'd2, 1'b0);
    send_round(32'd3215031751, 32'd3, 1'b0);
    send_round(32'd3215031751, 32'd5, 1'b0);
    send_round(32'd3215031751, 32'd7, 1'b1);
    send_round(32'd65537, 32'd65537, 1'b0);
    send_round(32'd6, 32'd2, 1'b0);
    send_round(32'd2147483647, 32'd3, 1'b0);
    send_round(32'd1105, 32'd2, 1'b1);
    send_round(32'd9, 32'd8, 1'b1);

    while (rounds_sent < 280) begin
      if ($urandom_range(0, 5) == 0) begin
        quiet <= !quiet;
      end
      run_sequence();
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);

    $display("Summary: %0d rounds sent, %0d result beats checked, %0d tests closed,",
             rounds_sent, checked, closed);
    $display("         covering trivial, prime, pseudoprime and random candidates.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* miller_rabin_prime_tester_core.f */
hw/rtl/mrpt_pkg.sv
hw/rtl/mrpt_modmul.sv
hw/rtl/mrpt_dp.sv
hw/rtl/mrpt_ctrl.sv
hw/rtl/miller_rabin_prime_tester_core.sv
bench/mrpt_round_checker.sv
bench/miller_rabin_prime_tester_core_test.sv
